>>> sv/wfls_pkg.sv
// Shared constants, word layouts and control structs of the fill level search.
`timescale 1ns / 1ps
`default_nettype none
package wfls_pkg;

  // Default sizing of the block
  localparam int TUBE_COUNT_DEF   = 65536;
  localparam int SEARCH_STEPS_DEF = 50;

  // Fixed arithmetic format
  localparam int HEIGHT_BITS   = 16;
  localparam int FRACTION_BITS = 16;
  localparam int RANGE_BITS    = 34;
  localparam int LEVEL_W       = RANGE_BITS + FRACTION_BITS + 1;
  localparam int MID_W         = LEVEL_W - 1;
  localparam int TREE_SIZE     = 1 << HEIGHT_BITS;

  // Stream word layouts
  localparam int TUBE_W     = 16;
  localparam int HEIGHT_W   = 16;
  localparam int VOLUME_W   = 32;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;

  // Input kind codes
  localparam logic KIND_SET   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic clr_write;
    logic look_read;
    logic old_load;
    logic new_load;
    logic upd_read;
    logic upd_write;
    logic mid_load;
    logic pre_read;
    logic pre_acc;
    logic mul;
    logic net;
    logic decide;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic set_in_range;
    logic old_valid;
    logic upd_end;
    logic pos_zero;
    logic remove_phase;
    logic steps_last;
  } stat_t;

endpackage
`default_nettype wire

>>> sv/water_fill_level_search.sv
// Top level of the water fill level search block.
`timescale 1ns / 1ps
`default_nettype none
// Keeps one height per tube in Fenwick trees of tube counts and height sums, indexed by
// height, and answers fill level queries by bisection. A set word (tuser = 0) walks the
// trees to add the new height, after first removing the old height when the tube
// holds a valid one. A query word (tuser = 1) runs SEARCH_STEPS bisection steps,
// each of which reads prefix nodes from the tree memories.
// After reset a clearing pass zeroes both trees and the tube valid bits before the first
// word is taken. The level is returned in units of 2^-17 and waits in an output
// register, so the next word can be taken while a result still sits there.
module water_fill_level_search
  import wfls_pkg::*;
#(
  parameter int TUBE_COUNT   = TUBE_COUNT_DEF,
  parameter int SEARCH_STEPS = SEARCH_STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // tube[15:0], height[31:16], volume[63:32]
  input  wire logic                  s_tuser,   // kind
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata    // level[50:0], zero fill
);

  cmd_t               cmd;
  stat_t              stat;
  logic [LEVEL_W-1:0] level;

  assign m_tdata = OUT_DATA_W'(level);

  wfls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wfls_datapath #(
    .TUBE_COUNT   (TUBE_COUNT),
    .SEARCH_STEPS (SEARCH_STEPS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .in_data (s_tdata),
    .cmd     (cmd),
    .stat    (stat),
    .level   (level)
  );

`ifndef SYNTHESIS
  // No word is taken in the cycle after reset releases
  a_clear_first: assert property (@(posedge clk) $past(rst) |-> !s_tready)
    else $error("word taken during clearing pass");

  // A query keeps the input closed on the following cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input open right after a query");

  // At most one memory write source per cycle
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_write, cmd.upd_write, cmd.new_load}))
    else $error("conflicting memory writes");

  // Reset empties the output register
  a_out_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");
`endif

endmodule
`default_nettype wire

>>> sv/wfls_datapath.sv
// Datapath: tube store, two Fenwick trees, prefix accumulator and bisection registers.
`timescale 1ns / 1ps
`default_nettype none
module wfls_datapath
  import wfls_pkg::*;
#(
  parameter int TUBE_COUNT   = TUBE_COUNT_DEF,
  parameter int SEARCH_STEPS = SEARCH_STEPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [IN_DATA_W-1:0] in_data,
  input  wire cmd_t                 cmd,
  output stat_t                     stat,
  output logic      [LEVEL_W-1:0]   level
);

  localparam int TUBE_BITS = $clog2(TUBE_COUNT);
  localparam int CNT_W     = $clog2(TUBE_COUNT + 1);
  localparam int SUM_W     = HEIGHT_BITS + TUBE_BITS;
  localparam int STEP_W    = $clog2(SEARCH_STEPS);
  localparam int CLR_N     = (TUBE_COUNT > TREE_SIZE) ? TUBE_COUNT : TREE_SIZE;
  localparam int CLR_W     = $clog2(CLR_N);
  localparam int POS_W     = HEIGHT_BITS + 1;
  localparam int PW_W      = CNT_W + RANGE_BITS;
  localparam int FW_W      = CNT_W + FRACTION_BITS;
  localparam int DEF_W     = VOLUME_W + FRACTION_BITS;
  localparam int CMP_W     = (FW_W > DEF_W) ? FW_W : DEF_W;
  localparam logic [LEVEL_W-1:0] TAIL_INIT = LEVEL_W'(1) << MID_W;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = '1;

  // Storage
  logic [HEIGHT_BITS-1:0] height_mem [TUBE_COUNT];
  logic                   valid_mem  [TUBE_COUNT];
  logic [CNT_W-1:0]       cnt_mem    [TREE_SIZE];
  logic [SUM_W-1:0]       sum_mem    [TREE_SIZE];

  // Registers
  logic [CLR_W-1:0]       clr_addr;
  logic [TUBE_W-1:0]      tube;
  logic [HEIGHT_BITS-1:0] h_new;
  logic [VOLUME_W-1:0]    volume;
  logic [HEIGHT_BITS-1:0] old_h;
  logic                   old_valid;
  logic [POS_W-1:0]       pos;
  logic [HEIGHT_BITS-1:0] upd_h;
  logic                   remove;
  logic [CNT_W-1:0]       rd_cnt;
  logic [SUM_W-1:0]       rd_sum;
  logic [CNT_W-1:0]       acc_cnt;
  logic [SUM_W-1:0]       acc_sum;
  logic [LEVEL_W-1:0]     head;
  logic [LEVEL_W-1:0]     tail;
  logic [MID_W-1:0]       mid;
  logic [STEP_W-1:0]      step;
  logic [PW_W-1:0]        prod_whole;
  logic [FW_W-1:0]        prod_frac;
  logic [PW_W-1:0]        whole_net;

  // Combinational helpers
  logic [POS_W-1:0]        lowbit;
  logic [HEIGHT_BITS-1:0]  tree_addr;
  logic [TUBE_BITS-1:0]    tube_addr;
  logic [LEVEL_W-1:0]      mid_sum;
  logic [RANGE_BITS-1:0]   li_next;
  logic [HEIGHT_BITS-1:0]  hidx;
  logic [RANGE_BITS-1:0]   li;
  logic [FRACTION_BITS-1:0] lf;
  logic [VOLUME_W-1:0]     deficit;
  logic                    whole_ge;
  logic                    frac_ge;
  logic                    clr_tree;
  logic                    clr_tube;

  assign lowbit    = pos & (~pos + POS_W'(1));
  assign tree_addr = HEIGHT_BITS'(pos - POS_W'(1));
  assign tube_addr = tube[TUBE_BITS-1:0];
  assign mid_sum   = head + tail;
  assign li_next   = mid_sum[LEVEL_W-1:FRACTION_BITS+1];
  assign hidx      = (|li_next[RANGE_BITS-1:HEIGHT_BITS]) ? HEIGHT_MAX
                                                          : li_next[HEIGHT_BITS-1:0];
  assign li        = mid[MID_W-1:FRACTION_BITS];
  assign lf        = mid[FRACTION_BITS-1:0];
  assign deficit   = volume - whole_net[VOLUME_W-1:0];
  assign whole_ge  = whole_net >= PW_W'(volume);
  assign frac_ge   = CMP_W'(prod_frac) >= CMP_W'({deficit, {FRACTION_BITS{1'b0}}});
  assign clr_tree  = cmd.clr_write && ({1'b0, clr_addr} < (CLR_W + 1)'(TREE_SIZE));
  assign clr_tube  = cmd.clr_write && ({1'b0, clr_addr} < (CLR_W + 1)'(TUBE_COUNT));

  // Status
  always_comb begin
    stat.clr_last     = clr_addr == CLR_W'(CLR_N - 1);
    stat.set_in_range = {1'b0, in_data[TUBE_W-1:0]} < (TUBE_W + 1)'(TUBE_COUNT);
    stat.old_valid    = old_valid;
    stat.upd_end      = (pos == '0) || (pos > POS_W'(TREE_SIZE));
    stat.pos_zero     = pos == '0;
    stat.remove_phase = remove;
    stat.steps_last   = step == STEP_W'(SEARCH_STEPS - 1);
  end

  // Sweep counter for the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_write && !stat.clr_last) begin
      clr_addr <= clr_addr + CLR_W'(1);
    end
  end

  // Tube height store
  always_ff @(posedge clk) begin
    if (cmd.new_load) begin
      height_mem[tube_addr] <= h_new;
    end
    if (cmd.look_read) begin
      old_h <= height_mem[tube_addr];
    end
  end

  // Tube valid store
  always_ff @(posedge clk) begin
    if (clr_tube) begin
      valid_mem[clr_addr[TUBE_BITS-1:0]] <= 1'b0;
    end else if (cmd.new_load) begin
      valid_mem[tube_addr] <= 1'b1;
    end
    if (cmd.look_read) begin
      old_valid <= valid_mem[tube_addr];
    end
  end

  // Count tree
  always_ff @(posedge clk) begin
    if (clr_tree) begin
      cnt_mem[clr_addr[HEIGHT_BITS-1:0]] <= '0;
    end else if (cmd.upd_write) begin
      cnt_mem[tree_addr] <= remove ? rd_cnt - CNT_W'(1) : rd_cnt + CNT_W'(1);
    end
    if (cmd.upd_read || cmd.pre_read) begin
      rd_cnt <= cnt_mem[tree_addr];
    end
  end

  // Sum tree
  always_ff @(posedge clk) begin
    if (clr_tree) begin
      sum_mem[clr_addr[HEIGHT_BITS-1:0]] <= '0;
    end else if (cmd.upd_write) begin
      sum_mem[tree_addr] <= remove ? rd_sum - SUM_W'(upd_h) : rd_sum + SUM_W'(upd_h);
    end
    if (cmd.upd_read || cmd.pre_read) begin
      rd_sum <= sum_mem[tree_addr];
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      tube   <= in_data[TUBE_W-1:0];
      h_new  <= HEIGHT_BITS'(in_data[TUBE_W +: HEIGHT_W]);
      volume <= in_data[TUBE_W+HEIGHT_W +: VOLUME_W];
    end
  end

  // Walk pointer and accumulators
  always_ff @(posedge clk) begin
    if (cmd.old_load) begin
      pos    <= {1'b0, old_h} + POS_W'(1);
      upd_h  <= old_h;
      remove <= 1'b1;
    end else if (cmd.new_load) begin
      pos    <= {1'b0, h_new} + POS_W'(1);
      upd_h  <= h_new;
      remove <= 1'b0;
    end else if (cmd.upd_write) begin
      pos <= pos + lowbit;
    end else if (cmd.mid_load) begin
      pos <= {1'b0, hidx} + POS_W'(1);
    end else if (cmd.pre_acc) begin
      pos <= pos - lowbit;
    end
    if (cmd.mid_load) begin
      acc_cnt <= '0;
      acc_sum <= '0;
    end else if (cmd.pre_acc) begin
      acc_cnt <= acc_cnt + rd_cnt;
      acc_sum <= acc_sum + rd_sum;
    end
  end

  // Bisection interval and test pipeline
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      head <= '0;
      tail <= TAIL_INIT;
      step <= '0;
    end else if (cmd.decide) begin
      if (whole_ge || frac_ge) begin
        tail <= LEVEL_W'(mid);
      end else begin
        head <= LEVEL_W'(mid);
      end
      step <= step + STEP_W'(1);
    end
    if (cmd.mid_load) begin
      mid <= mid_sum[LEVEL_W-1:1];
    end
    if (cmd.mul) begin
      prod_whole <= PW_W'(acc_cnt) * PW_W'(li);
      prod_frac  <= FW_W'(acc_cnt) * FW_W'(lf);
    end
    if (cmd.net) begin
      whole_net <= (prod_whole >= PW_W'(acc_sum)) ? prod_whole - PW_W'(acc_sum) : '0;
    end
    if (cmd.out_load) begin
      level <= head + tail;
    end
  end

endmodule
`default_nettype wire

>>> sv/wfls_ctrl.sv
// Controller: sequences clearing, height updates and bisection steps.
`timescale 1ns / 1ps
`default_nettype none
module wfls_ctrl
  import wfls_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  input  wire logic  s_tuser,
  output logic       m_tvalid,
  input  wire logic  m_tready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_LOOK   = 4'd2;
  localparam logic [3:0] ST_CHECK  = 4'd3;
  localparam logic [3:0] ST_WRITE  = 4'd4;
  localparam logic [3:0] ST_URD    = 4'd5;
  localparam logic [3:0] ST_UWR    = 4'd6;
  localparam logic [3:0] ST_MID    = 4'd7;
  localparam logic [3:0] ST_PRD    = 4'd8;
  localparam logic [3:0] ST_PACC   = 4'd9;
  localparam logic [3:0] ST_MUL    = 4'd10;
  localparam logic [3:0] ST_NET    = 4'd11;
  localparam logic [3:0] ST_DECIDE = 4'd12;
  localparam logic [3:0] ST_OUT    = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign s_tready = state == ST_IDLE;
  assign out_free = !m_tvalid || m_tready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          if (s_tuser == KIND_QUERY) state_next = ST_MID;
          else if (stat.set_in_range) state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look_read = 1'b1;
        state_next    = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.old_valid) begin
          cmd.old_load = 1'b1;
          state_next   = ST_URD;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.new_load = 1'b1;
        state_next   = ST_URD;
      end
      ST_URD: begin
        if (stat.upd_end) begin
          state_next = stat.remove_phase ? ST_WRITE : ST_IDLE;
        end else begin
          cmd.upd_read = 1'b1;
          state_next   = ST_UWR;
        end
      end
      ST_UWR: begin
        cmd.upd_write = 1'b1;
        state_next    = ST_URD;
      end
      ST_MID: begin
        cmd.mid_load = 1'b1;
        state_next   = ST_PRD;
      end
      ST_PRD: begin
        if (stat.pos_zero) begin
          state_next = ST_MUL;
        end else begin
          cmd.pre_read = 1'b1;
          state_next   = ST_PACC;
        end
      end
      ST_PACC: begin
        cmd.pre_acc = 1'b1;
        state_next  = ST_PRD;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_NET;
      end
      ST_NET: begin
        cmd.net    = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = stat.steps_last ? ST_OUT : ST_MID;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
